// File: rtl/core/lpht_pkg.sv
// Shared types and constants for the linear probe hash table.
package lpht_pkg;
    typedef enum logic [2:0] {
        ACT_SET     = 3'd0,
        ACT_GET     = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_ITERATE = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    localparam logic [63:0] HASH_ADD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] HASH_MUL2 = 64'h94D049BB133111EB;
    localparam int unsigned LOAD_DENOM = 10;
    localparam logic [3:0] LOAD_RESET = 4'd7;
endpackage

// File: rtl/core/lpht_mul64.sv
// 64x64 low-half multiplier, one 32x32 partial product per cycle.
module lpht_mul64 import lpht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic [63:0] r_a, r_b, r_acc;
    logic [2:0]  r_step;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    always_comb begin
        w_x = r_a[31:0];
        w_y = r_b[31:0];
        if (r_step == 3'd2) w_x = r_a[63:32];
        if (r_step == 3'd3) w_y = r_b[63:32];
        w_pp = w_x * w_y;
    end

    // step1: lo*lo, step2: hi*lo, step3: lo*hi
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
        end else if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_acc <= 64'd0;
            r_step <= 3'd1;
        end else if (r_step == 3'd1) begin
            r_acc <= w_pp;
            r_step <= 3'd2;
        end else if (r_step == 3'd2) begin
            r_acc <= r_acc + {w_pp[31:0], 32'd0};
            r_step <= 3'd3;
        end else if (r_step == 3'd3) begin
            r_acc <= r_acc + {w_pp[31:0], 32'd0};
            r_step <= 3'd4;
        end else if (r_step == 3'd4) begin
            r_step <= 3'd0;
        end
    end

    assign o_done = (r_step == 3'd4);
    assign o_p    = r_acc;
endmodule

// File: rtl/core/lpht_front.sv
// Front end: accepts items, hashes the keys of set, get and erase items, queues classified work.
module lpht_front import lpht_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [2:0]               i_action,
    input  logic [63:0]              i_key,
    input  logic [63:0]              i_value,
    input  logic [10:0]              i_cursor,
    output logic                     o_qvalid,
    input  logic                     i_qpop,
    output logic [2:0]               o_action,
    output logic [63:0]              o_key,
    output logic [63:0]              o_value,
    output logic [10:0]              o_cursor,
    output logic [$clog2(SLOTS)-1:0] o_home
);
    localparam int AW = $clog2(SLOTS);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_M1 = 5'b00010, S_M2 = 5'b00100,
        S_FIN = 5'b01000, S_PUT = 5'b10000
    } t_fstate;

    t_fstate r_st;
    logic [2:0]  r_act;
    logic [63:0] r_key, r_val, r_x;
    logic [10:0] r_cur;
    logic        m_start, m_done;
    logic [63:0] m_a, m_b, m_p;

    // two-entry queue
    logic [2:0]  r_qa [2];
    logic [63:0] r_qk [2];
    logic [63:0] r_qv [2];
    logic [10:0] r_qc [2];
    logic [AW-1:0] r_qh [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_qpush;

    lpht_mul64 u_mul (.i_clk, .i_rst_n, .i_start(m_start), .i_a(m_a), .i_b(m_b),
                      .o_done(m_done), .o_p(m_p));

    assign full = (r_st != S_IDLE);
    assign w_qpush = (r_st == S_PUT) && (r_cnt != 2'd2);

    always_comb begin
        m_start = 1'b0;
        m_a = r_x ^ (r_x >> 30);
        m_b = HASH_MUL1;
        if (r_st == S_IDLE && push && i_action == ACT_SET || r_st == S_IDLE && push &&
            (i_action == ACT_GET || i_action == ACT_ERASE)) begin
            m_start = 1'b1;
            m_a = (i_key + HASH_ADD) ^ ((i_key + HASH_ADD) >> 30);
        end else if (r_st == S_M1 && m_done) begin
            m_start = 1'b1;
            m_a = m_p ^ (m_p >> 27);
            m_b = HASH_MUL2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: if (push) begin
                    r_act <= i_action; r_key <= i_key; r_val <= i_value; r_cur <= i_cursor;
                    r_x <= 64'd0;
                    r_st <= m_start ? S_M1 : S_PUT;
                end
                S_M1: if (m_done) r_st <= S_M2;
                S_M2: if (m_done) begin
                    r_x <= m_p ^ (m_p >> 31);
                    r_st <= S_PUT;
                end
                S_FIN: r_st <= S_PUT;
                S_PUT: if (w_qpush) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qpush) begin
            r_qa[r_wp] <= r_act; r_qk[r_wp] <= r_key; r_qv[r_wp] <= r_val;
            r_qc[r_wp] <= r_cur; r_qh[r_wp] <= r_x[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_qpush) r_wp <= ~r_wp;
            if (i_qpop && o_qvalid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_qpush} - {1'b0, i_qpop && o_qvalid};
        end
    end

    assign o_qvalid = (r_cnt != 2'd0);
    assign o_action = r_qa[r_rp];
    assign o_key    = r_qk[r_rp];
    assign o_value  = r_qv[r_rp];
    assign o_cursor = r_qc[r_rp];
    assign o_home   = r_qh[r_rp];
endmodule

// File: rtl/core/lpht_back.sv
// Back end: slot store, probe sequencer and result register.
module lpht_back import lpht_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_qvalid,
    output logic                     o_qpop,
    input  logic [2:0]               i_action,
    input  logic [63:0]              i_key,
    input  logic [63:0]              i_value,
    input  logic [10:0]              i_cursor,
    input  logic [$clog2(SLOTS)-1:0] i_home,
    input  logic [3:0]               i_limit,
    output logic                     empty,
    input  logic                     pop,
    output logic [1:0]               o_status,
    output logic [63:0]              o_out_key,
    output logic [63:0]              o_found_value,
    output logic [10:0]              o_next_cursor,
    output logic [10:0]              o_live_count
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_INIT = 7'b0000010, S_RD = 7'b0000100,
        S_CHK = 7'b0001000, S_WR = 7'b0010000, S_CLR = 7'b0100000,
        S_OUT = 7'b1000000
    } t_bstate;

    t_bstate r_st;
    logic [63:0] r_keys [SLOTS];
    logic [63:0] r_vals [SLOTS];
    logic [1:0]  r_marks [SLOTS];
    logic [63:0] r_rk, r_rv;
    logic [1:0]  r_rm;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_n, r_live, r_dead;
    logic [2:0]  r_act;
    logic [63:0] r_key, r_val;
    logic        r_iter;
    logic        r_we_m, r_we_kv, r_we_v;
    logic [1:0]  r_wm;
    logic        r_ovalid;
    logic [1:0]  r_ost;
    logic [63:0] r_ok, r_ov;
    logic [10:0] r_oc;
    logic [CW+3:0] w_need;
    logic [CW+4:0] w_lim;
    logic        w_ok_ins;
    logic [1:0]  r_rost;
    logic [63:0] r_rok, r_rov;
    logic [10:0] r_roc, r_rlc;

    assign w_need = ({4'd0, r_live} + {4'd0, r_dead} + 1'b1) * (CW+4)'(LOAD_DENOM);
    assign w_lim  = (CW+5)'(SLOTS) * (CW+5)'(i_limit);
    assign w_ok_ins = ({1'b0, w_need} < w_lim);

    // next item may run while the previous result waits in the output register
    assign o_qpop = (r_st == S_IDLE) && i_qvalid;

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        r_rk <= r_keys[r_addr];
        r_rv <= r_vals[r_addr];
        r_rm <= r_marks[r_addr];
        if (r_we_kv) r_keys[r_addr] <= r_key;
        if (r_we_v)  r_vals[r_addr] <= r_val;
        if (r_we_m)  r_marks[r_addr] <= r_wm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_addr <= '0; r_live <= '0; r_dead <= '0;
            r_ovalid <= 1'b0; r_we_m <= 1'b1; r_wm <= MARK_EMPTY;
            r_we_kv <= 1'b0; r_we_v <= 1'b0; r_act <= ACT_CLEAR;
            r_n <= '1;
        end else begin
            r_we_m <= 1'b0; r_we_kv <= 1'b0; r_we_v <= 1'b0;
            if (pop && r_ovalid) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_qpop) begin
                    r_act <= i_action; r_key <= i_key; r_val <= i_value;
                    r_n <= '0; r_ok <= '0; r_ov <= '0; r_oc <= '0; r_ost <= ST_NOTFOUND;
                    r_iter <= (i_action == ACT_ITERATE);
                    if (i_action == ACT_CLEAR) begin
                        r_addr <= '0; r_we_m <= 1'b1; r_wm <= MARK_EMPTY; r_st <= S_CLR;
                    end else if (i_action == ACT_ITERATE) begin
                        if (i_cursor >= 11'(SLOTS)) r_st <= S_OUT;
                        else begin
                            r_addr <= i_cursor[AW-1:0];
                            r_n <= CW'(i_cursor);
                            r_st <= S_RD;
                        end
                    end else if (i_action == ACT_SET || i_action == ACT_GET ||
                                 i_action == ACT_ERASE) begin
                        r_addr <= i_home; r_st <= S_RD;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_RD: r_st <= S_CHK;
                S_CHK: begin
                    if (r_iter) begin
                        if (r_rm == MARK_LIVE) begin
                            r_ost <= ST_OK; r_ok <= r_rk; r_ov <= r_rv;
                            r_oc <= 11'(r_n + 1'b1); r_st <= S_OUT;
                        end else if (r_n == CW'(SLOTS - 1)) begin
                            r_st <= S_OUT;
                        end else begin
                            r_n <= r_n + 1'b1; r_addr <= r_addr + 1'b1; r_st <= S_RD;
                        end
                    end else if (r_rm == MARK_LIVE && r_rk == r_key) begin
                        r_st <= S_OUT;
                        unique case (r_act)
                            ACT_SET: begin r_ost <= ST_OK; r_we_v <= 1'b1; end
                            ACT_GET: begin r_ost <= ST_OK; r_ov <= r_rv; end
                            default: begin
                                r_ost <= ST_OK; r_we_m <= 1'b1; r_wm <= MARK_DEAD;
                                r_val <= '0; r_we_v <= 1'b1;
                                r_live <= r_live - 1'b1; r_dead <= r_dead + 1'b1;
                            end
                        endcase
                    end else if (r_rm == MARK_EMPTY || r_n == CW'(SLOTS - 1)) begin
                        r_st <= S_OUT;
                        if (r_act == ACT_SET) begin
                            if (w_ok_ins && r_rm == MARK_EMPTY) begin
                                r_ost <= ST_OK; r_we_kv <= 1'b1; r_we_v <= 1'b1;
                                r_we_m <= 1'b1; r_wm <= MARK_LIVE;
                                r_live <= r_live + 1'b1;
                            end else begin
                                r_ost <= ST_FULL;
                            end
                        end
                    end else begin
                        r_n <= r_n + 1'b1; r_addr <= r_addr + 1'b1; r_st <= S_RD;
                    end
                end
                S_CLR: begin
                    if (r_addr == AW'(SLOTS - 1)) begin
                        r_live <= '0; r_dead <= '0; r_ost <= ST_OK;
                        r_st <= S_OUT;
                    end else begin
                        r_addr <= r_addr + 1'b1; r_we_m <= 1'b1; r_wm <= MARK_EMPTY;
                    end
                end
                S_OUT: begin
                    // reset sweep produces no result
                    if (r_act == ACT_CLEAR && r_n == '1) r_st <= S_IDLE;
                    else if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_rost <= r_ost;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && !r_ovalid) begin
            r_rok <= r_ok; r_rov <= r_ov; r_roc <= r_oc; r_rlc <= 11'(r_live);
        end
    end

    assign empty = !r_ovalid;
    assign o_status = r_rost;
    assign o_out_key = r_rok;
    assign o_found_value = r_rov;
    assign o_next_cursor = r_roc;
    assign o_live_count = r_rlc;
endmodule

// File: rtl/core/linear_probe_hash_table.sv
// Top level of the linear probe hash table.
// A keyed action probes slots from its home slot onward; iterate scans from the cursor;
// clear sweeps every slot. The front accepts a new item only once the previous one is
// queued, keyed items after the two hash multiplies; the back pops the next queued item
// while a result waits in its output register.
// Reset: synchronous, active low; a sweep then empties the marks of every slot.
module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    input  logic [10:0] i_cursor,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_key,
    output logic [63:0] o_found_value,
    output logic [10:0] o_next_cursor,
    output logic [10:0] o_live_count,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0] r_limit;
    logic q_valid, q_pop;
    logic [2:0] q_act;
    logic [63:0] q_key, q_val;
    logic [10:0] q_cur;
    logic [$clog2(SLOTS)-1:0] q_home;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LOAD_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_data;
    end

    lpht_front #(.SLOTS(SLOTS)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_action, .i_key, .i_value, .i_cursor,
        .o_qvalid(q_valid), .i_qpop(q_pop), .o_action(q_act), .o_key(q_key),
        .o_value(q_val), .o_cursor(q_cur), .o_home(q_home));

    lpht_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_qvalid(q_valid), .o_qpop(q_pop), .i_action(q_act),
        .i_key(q_key), .i_value(q_val), .i_cursor(q_cur), .i_home(q_home),
        .i_limit(r_limit), .empty, .pop, .o_status, .o_out_key, .o_found_value,
        .o_next_cursor, .o_live_count);
endmodule

// File: rtl/core/lpht_checker.sv
// Port-level checker for the linear probe hash table.
module lpht_checker import lpht_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [63:0] o_found_value,
    input logic [10:0] o_next_cursor
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= ST_FULL) else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty) else $error("result dropped");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == ST_FULL |-> o_found_value == 64'd0 && o_next_cursor == 11'd0)
        else $error("full result carries data");
endmodule

bind linear_probe_hash_table lpht_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_status, .o_found_value, .o_next_cursor);
